FILE: rtl/base64_encoder_url_escape_top_defines.svh
// Assertion macros for the base64 encoder RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef BASE64_ENCODER_URL_ESCAPE_TOP_DEFINES_SVH
`define BASE64_ENCODER_URL_ESCAPE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define B64UE_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define B64UE_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/b64ue_pkg.sv
// Shared types, ASCII constants and the base64 alphabet mapping.
// No dependencies.
package b64ue_pkg;

	localparam logic [7:0] ASC_UPPER_A = 8'h41;
	localparam logic [7:0] ASC_LOWER_A = 8'h61;
	localparam logic [7:0] ASC_DIGIT_0 = 8'h30;
	localparam logic [7:0] ASC_PLUS    = 8'h2B;
	localparam logic [7:0] ASC_SLASH   = 8'h2F;
	localparam logic [7:0] ASC_EQ      = 8'h3D;
	localparam logic [7:0] ASC_PCT     = 8'h25;
	localparam logic [7:0] ASC_TWO     = 8'h32;
	localparam logic [7:0] ASC_THREE   = 8'h33;
	localparam logic [7:0] ASC_UPPER_B = 8'h42;
	localparam logic [7:0] ASC_UPPER_D = 8'h44;
	localparam logic [7:0] ASC_UPPER_F = 8'h46;

	localparam logic [5:0] SYM_LOWER_START = 6'd26;
	localparam logic [5:0] SYM_DIGIT_START = 6'd52;
	localparam logic [5:0] SYM_PLUS        = 6'd62;

	// One encoded group: four base characters (symbols and pads) and the final mark.
	typedef struct packed {
		logic [3:0][7:0] chars;
		logic            fin;
	} b64ue_group_t;

	function automatic logic [7:0] b64_char(input logic [5:0] s);
		logic [7:0] c;
		if (s < SYM_LOWER_START) begin
			c = ASC_UPPER_A + {2'b00, s};
		end else if (s < SYM_DIGIT_START) begin
			c = ASC_LOWER_A + {2'b00, s - SYM_LOWER_START};
		end else if (s < SYM_PLUS) begin
			c = ASC_DIGIT_0 + {2'b00, s - SYM_DIGIT_START};
		end else if (s == SYM_PLUS) begin
			c = ASC_PLUS;
		end else begin
			c = ASC_SLASH;
		end
		return c;
	endfunction

endpackage

FILE: rtl/b64ue_group.sv
// Input stage: collects bytes into groups of up to three and maps each group to four characters.
// Depends on b64ue_pkg.
module b64ue_group (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [7:0]             data_byte,
	input  logic                   final_byte,
	input  logic                   take,
	output logic                   grp_valid,
	output b64ue_pkg::b64ue_group_t grp
);
	import b64ue_pkg::*;

	logic [1:0]   cnt_q;
	logic [15:0]  pend_q;
	logic         valid_s1;
	b64ue_group_t grp_s1;

	logic         accept;
	logic         completes;
	logic [7:0]   g0, g1, g2;
	logic [5:0]   sym0, sym1, sym2, sym3;
	b64ue_group_t grp_next;

	assign in_ready  = !valid_s1 || take;
	assign accept    = in_valid && in_ready;
	assign completes = final_byte || (cnt_q == 2'd2);

	always_comb begin
		g0 = data_byte;
		g1 = 8'h00;
		g2 = 8'h00;
		if (cnt_q == 2'd1) begin
			g0 = pend_q[15:8];
			g1 = data_byte;
		end else if (cnt_q == 2'd2) begin
			g0 = pend_q[15:8];
			g1 = pend_q[7:0];
			g2 = data_byte;
		end
		sym0 = g0[7:2];
		sym1 = {g0[1:0], g1[7:4]};
		sym2 = {g1[3:0], g2[7:6]};
		sym3 = g2[5:0];
		grp_next.chars[0] = b64_char(sym0);
		grp_next.chars[1] = b64_char(sym1);
		// pad the positions past the bytes actually present
		grp_next.chars[2] = (cnt_q != 2'd0) ? b64_char(sym2) : ASC_EQ;
		grp_next.chars[3] = (cnt_q == 2'd2) ? b64_char(sym3) : ASC_EQ;
		grp_next.fin      = final_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= 2'd0;
			pend_q   <= 16'h0000;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				if (completes) begin
					cnt_q  <= 2'd0;
					pend_q <= 16'h0000;
				end else if (cnt_q == 2'd0) begin
					cnt_q  <= 2'd1;
					pend_q <= {data_byte, 8'h00};
				end else begin
					cnt_q  <= 2'd2;
					pend_q <= {pend_q[15:8], data_byte};
				end
			end
			if (accept && completes) begin
				valid_s1 <= 1'b1;
			end else if (take) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && completes) begin
			grp_s1 <= grp_next;
		end
	end

	assign grp_valid = valid_s1;
	assign grp       = grp_s1;

endmodule

FILE: rtl/b64ue_emit.sv
// Output stage: walks the four characters of a group, expands escapes, drives the output register.
// Depends on b64ue_pkg and base64_encoder_url_escape_top_defines.svh.
`include "base64_encoder_url_escape_top_defines.svh"

module b64ue_emit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   url_mode,
	input  logic                   grp_valid,
	input  b64ue_pkg::b64ue_group_t grp,
	output logic                   take,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [7:0]             out_char,
	output logic                   run_end,
	output logic                   stream_end
);
	import b64ue_pkg::*;

	b64ue_group_t w_q;
	logic         w_valid_q;
	logic [1:0]   ci_q;
	logic [1:0]   ep_q;
	logic         out_valid_q;
	logic [7:0]   out_char_q;
	logic         run_end_q;
	logic         stream_end_q;

	logic [7:0]   cur;
	logic         cur_esc;
	logic [7:0]   piece;
	logic         last_piece;
	logic         last_grp;
	logic         adv;

	assign cur     = w_q.chars[ci_q];
	assign cur_esc = url_mode && (cur == ASC_PLUS || cur == ASC_SLASH || cur == ASC_EQ);

	always_comb begin
		piece = cur;
		if (cur_esc) begin
			case (ep_q)
				2'd0: piece = ASC_PCT;
				2'd1: piece = (cur == ASC_EQ) ? ASC_THREE : ASC_TWO;
				default: begin
					if (cur == ASC_PLUS) begin
						piece = ASC_UPPER_B;
					end else if (cur == ASC_SLASH) begin
						piece = ASC_UPPER_F;
					end else begin
						piece = ASC_UPPER_D;
					end
				end
			endcase
		end
	end

	assign last_piece = !cur_esc || (ep_q == 2'd2);
	assign last_grp   = last_piece && (ci_q == 2'd3);
	assign adv        = w_valid_q && (!out_valid_q || out_ready);
	assign take       = grp_valid && (!w_valid_q || (adv && last_grp));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_valid_q   <= 1'b0;
			ci_q        <= 2'd0;
			ep_q        <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take) begin
				w_valid_q <= 1'b1;
				ci_q      <= 2'd0;
				ep_q      <= 2'd0;
			end else if (adv) begin
				if (last_grp) begin
					w_valid_q <= 1'b0;
					ci_q      <= 2'd0;
					ep_q      <= 2'd0;
				end else if (last_piece) begin
					ci_q <= ci_q + 2'd1;
					ep_q <= 2'd0;
				end else begin
					ep_q <= ep_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			w_q <= grp;
		end
		if (adv) begin
			out_char_q   <= piece;
			run_end_q    <= last_grp;
			stream_end_q <= last_grp && w_q.fin;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_char   = out_char_q;
	assign run_end    = run_end_q;
	assign stream_end = stream_end_q;

	`B64UE_ASSERT_NOW(a_stream_end_on_run_end, clk, arst_n, out_valid_q && stream_end_q, run_end_q, "stream end without run end")
	`B64UE_ASSERT_NOW(a_escape_in_progress, clk, arst_n, w_valid_q && (ep_q != 2'd0), cur_esc, "escape step on a plain character")
	`B64UE_ASSERT_NEXT(a_group_drains, clk, arst_n, adv && last_grp && !grp_valid, !w_valid_q, "work register kept after last beat of group")

endmodule

FILE: rtl/base64_encoder_url_escape_top.sv
// Top level of the streaming base64 encoder with optional percent escaping.
// Depends on b64ue_pkg, b64ue_group and b64ue_emit.
//
// Bytes enter one per beat with a final mark; every third byte, or the final byte, closes a group
// that becomes four characters (symbols, then '=' pads). In URL mode '+', '/' and '=' leave as
// %2B, %2F and %3D. A byte is taken as long as the group register is free or is being handed on;
// each group then occupies the output serializer for one output character per plain character
// and three per escaped one, and the sustained rate is one output character per cycle while
// out_ready is high. Write url_mode only while no characters are pending.
module base64_encoder_url_escape_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       url_mode,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       final_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       run_end,
	output logic       stream_end
);
	import b64ue_pkg::*;

	logic         url_mode_q;
	logic         grp_valid;
	logic         take;
	b64ue_group_t grp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			url_mode_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			url_mode_q <= url_mode;
		end
	end

	b64ue_group u_group (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.take       (take),
		.grp_valid  (grp_valid),
		.grp        (grp)
	);

	b64ue_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.url_mode   (url_mode_q),
		.grp_valid  (grp_valid),
		.grp        (grp),
		.take       (take),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_char   (out_char),
		.run_end    (run_end),
		.stream_end (stream_end)
	);

endmodule
